>>> src/tlcf_pkg.sv
// Shared types and constants for the text line cell formatter.
package tlcf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 256;
   localparam int TAB_STOP_DEFAULT  = 8;

   localparam int LINE_WIDTH_W = 9;
   localparam int POSITION_W   = 24;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic       KIND_TEXT = 1'b0;
   localparam logic       KIND_EOT  = 1'b1;

   localparam logic [2:0] REG_NORMAL_COLOR = 3'd0;
   localparam logic [2:0] REG_SELECT_COLOR = 3'd1;
   localparam logic [2:0] REG_SEL_START    = 3'd2;
   localparam logic [2:0] REG_SEL_END      = 3'd3;
   localparam logic [2:0] REG_LINE_WIDTH   = 3'd4;

   localparam logic [7:0]              NORMAL_COLOR_RESET = 8'd7;
   localparam logic [7:0]              SELECT_COLOR_RESET = 8'd112;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET   = 9'd80;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            character;
      logic [POSITION_W-1:0] position;
      logic                  line_start;
   } req_data_type;

   typedef struct packed {
      logic [7:0]              cell_char;
      logic [7:0]              cell_color;
      logic [LINE_WIDTH_W-1:0] run_length;
      logic                    line_end;
   } rsp_data_type;

endpackage

>>> src/text_line_cell_formatter.sv
// Text line cell formatter: turns text bytes into runs of screen cells for one line.
//
// Input channel req_*: one transfer per text byte or end-of-text item, with its
// text position and a flag that starts a new display line.
// Result channel rsp_*: at most one run (character, color, count, line end) per
// input transfer; items that fall past the end of a line give no run.
// Configuration port csr_*: APB-style, registers at byte addresses 0x00 normal
// color, 0x04 select color, 0x08 selection start, 0x0c selection end, 0x10 line
// width. pready is always high; reads return the register value.
// An accepted item goes into the input register, then into the run register on rsp_*.
// Throughput: one item per cycle unless a pending run is stalled; the column, tab phase
// and line-done state are updated in one pass of logic between the input register and
// the run register. A stalled receiver holds the run register; one more item waits in
// the input register, and req_ready drops only when both are full.
// Reset clears both stages, the column and line state, and loads the register
// reset values: normal color 7, select color 112, empty selection, width 80.
module text_line_cell_formatter
   import tlcf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int TAB_STOP  = TAB_STOP_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int EW  = (CW > LINE_WIDTH_W) ? CW : LINE_WIDTH_W;
   localparam int TPW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

   logic [7:0]              normal_color_ff;
   logic [7:0]              select_color_ff;
   logic [POSITION_W-1:0]   sel_start_ff;
   logic [POSITION_W-1:0]   sel_end_ff;
   logic [LINE_WIDTH_W-1:0] line_width_ff;

   logic                    in_valid_ff;
   req_data_type            in_data_ff;
   logic                    rsp_valid_ff;
   rsp_data_type            rsp_data_ff;
   rsp_data_type            rsp_data_in;
   logic                    emit;

   logic [CW-1:0]           column_ff;
   logic [CW-1:0]           column_in;
   logic                    line_done_ff;
   logic                    line_done_in;
   logic [TPW-1:0]          phase_ff;
   logic [TPW-1:0]          phase_in;

   logic                    out_free;
   logic                    csr_write;
   logic [2:0]              csr_index;

   logic [CW-1:0]           col;
   logic                    done;
   logic [TPW-1:0]          ph;
   logic [TPW:0]            ph_inc;
   logic [EW-1:0]           lw_ext;
   logic [EW-1:0]           width;
   logic [EW-1:0]           col_ext;
   logic [EW-1:0]           left;
   logic [EW-1:0]           tab_n;
   logic [EW-1:0]           n;
   logic [EW-1:0]           col_sum;
   logic                    selected;
   logic [7:0]              color;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !in_valid_ff || out_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         REG_NORMAL_COLOR: csr_prdata = CSR_DATA_W'(normal_color_ff);
         REG_SELECT_COLOR: csr_prdata = CSR_DATA_W'(select_color_ff);
         REG_SEL_START:    csr_prdata = CSR_DATA_W'(sel_start_ff);
         REG_SEL_END:      csr_prdata = CSR_DATA_W'(sel_end_ff);
         REG_LINE_WIDTH:   csr_prdata = CSR_DATA_W'(line_width_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      col  = in_data_ff.line_start ? '0 : column_ff;
      done = in_data_ff.line_start ? 1'b0 : line_done_ff;
      ph   = in_data_ff.line_start ? '0 : phase_ff;

      lw_ext = EW'(line_width_ff);
      if (lw_ext == '0) begin
         width = EW'(1);
      end else if (lw_ext > EW'(MAX_WIDTH)) begin
         width = EW'(MAX_WIDTH);
      end else begin
         width = lw_ext;
      end

      col_ext  = EW'(col);
      left     = width - col_ext;
      tab_n    = EW'(TAB_STOP) - EW'(ph);
      ph_inc   = {1'b0, ph} + (TPW+1)'(1);
      selected = (in_data_ff.position >= sel_start_ff) && (in_data_ff.position < sel_end_ff);
      color    = selected ? select_color_ff : normal_color_ff;

      emit         = 1'b0;
      column_in    = col;
      line_done_in = done;
      phase_in     = ph;
      n            = EW'(1);
      col_sum      = col_ext + n;
      rsp_data_in.cell_char  = in_data_ff.character;
      rsp_data_in.cell_color = color;
      rsp_data_in.run_length = LINE_WIDTH_W'(left);
      rsp_data_in.line_end   = 1'b1;

      if (done) begin
         emit = 1'b0;
      end else if (col_ext >= width) begin
         line_done_in = 1'b1;
      end else if (in_data_ff.kind == KIND_EOT) begin
         emit                   = 1'b1;
         rsp_data_in.cell_char  = CHAR_SPACE;
         rsp_data_in.cell_color = normal_color_ff;
         column_in              = CW'(width);
         line_done_in           = 1'b1;
      end else if (in_data_ff.character == CHAR_LF || in_data_ff.character == CHAR_CR) begin
         emit                  = 1'b1;
         rsp_data_in.cell_char = CHAR_SPACE;
         column_in             = CW'(width);
         line_done_in          = 1'b1;
      end else begin
         emit = 1'b1;
         if (in_data_ff.character == CHAR_TAB) begin
            n                     = (tab_n > left) ? left : tab_n;
            rsp_data_in.cell_char = CHAR_SPACE;
            phase_in              = '0;
         end else begin
            phase_in = (ph_inc == (TPW+1)'(TAB_STOP)) ? '0 : TPW'(ph_inc);
         end
         col_sum                = col_ext + n;
         column_in              = CW'(col_sum);
         line_done_in           = (col_sum >= width);
         rsp_data_in.run_length = LINE_WIDTH_W'(n);
         rsp_data_in.line_end   = (col_sum >= width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         column_ff       <= '0;
         line_done_ff    <= 1'b0;
         phase_ff        <= '0;
         normal_color_ff <= NORMAL_COLOR_RESET;
         select_color_ff <= SELECT_COLOR_RESET;
         sel_start_ff    <= '0;
         sel_end_ff      <= '0;
         line_width_ff   <= LINE_WIDTH_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff && emit;
            if (in_valid_ff) begin
               column_ff    <= column_in;
               line_done_ff <= line_done_in;
               phase_ff     <= phase_in;
            end
         end
         if (csr_write) begin
            case (csr_index)
               REG_NORMAL_COLOR: normal_color_ff <= csr_pwdata[7:0];
               REG_SELECT_COLOR: select_color_ff <= csr_pwdata[7:0];
               REG_SEL_START:    sel_start_ff    <= csr_pwdata[POSITION_W-1:0];
               REG_SEL_END:      sel_end_ff      <= csr_pwdata[POSITION_W-1:0];
               REG_LINE_WIDTH:   line_width_ff   <= csr_pwdata[LINE_WIDTH_W-1:0];
               default:          ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (out_free && in_valid_ff && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a pending run ends the line exactly when the line state says done
   a_done_matches_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (line_done_ff == rsp_data_ff.line_end))
      else $error("line state disagrees with pending run");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.run_length != '0))
      else $error("empty run presented");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      EW'(column_ff) <= EW'(MAX_WIDTH))
      else $error("column beyond maximum width");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      (TPW+1)'(phase_ff) < (TPW+1)'(TAB_STOP))
      else $error("tab phase out of range");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(column_ff) && $stable(line_done_ff)))
      else $error("line state moved while the run register was stalled");

endmodule

>>> verif/text_line_cell_formatter_test.sv
// Self-checking testbench for text_line_cell_formatter: directed and random text streams.
module text_line_cell_formatter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tlcf_pkg::*;

   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 4;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_data_type          req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the block's registers and line state
   logic [7:0]              shadow_normal    = NORMAL_COLOR_RESET;
   logic [7:0]              shadow_select    = SELECT_COLOR_RESET;
   logic [POSITION_W-1:0]   shadow_sel_start = '0;
   logic [POSITION_W-1:0]   shadow_sel_end   = '0;
   logic [LINE_WIDTH_W-1:0] shadow_width     = LINE_WIDTH_RESET;
   int                      line_column      = 0;
   bit                      line_closed      = 1'b0;

   req_data_type text_items[$];
   rsp_data_type expected_runs[$];

   int send_idle_pct  = 12;
   int recv_idle_pct  = 86;
   int stall_requests = 0;
   int stall_served   = 0;
   int stall_left     = 0;
   int fail_count     = 0;
   int items_sent     = 0;
   int runs_checked   = 0;
   int line_ends      = 0;
   int reg_writes     = 0;
   int quiet_cycles   = 0;
   int text_pos       = 0;

   always #6 clock = ~clock;

   text_line_cell_formatter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic int effective_width();
      int w;
      w = shadow_width;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
      return w;
   endfunction

   function automatic void predict_run(req_data_type item);
      int         w;
      int         left;
      int         n;
      logic [7:0] color;
      logic [7:0] glyph;
      if (item.line_start) begin
         line_column = 0;
         line_closed = 1'b0;
      end
      if (line_closed) return;
      w = effective_width();
      if (line_column >= w) begin
         line_closed = 1'b1;
         return;
      end
      left  = w - line_column;
      glyph = CHAR_SPACE;
      if (item.kind == KIND_EOT) begin
         color = shadow_normal;
         n     = left;
      end else begin
         color = (item.position >= shadow_sel_start && item.position < shadow_sel_end) ?
                 shadow_select : shadow_normal;
         if (item.character == CHAR_LF || item.character == CHAR_CR) begin
            n = left;
         end else if (item.character == CHAR_TAB) begin
            n = TAB_STOP_DEFAULT - line_column % TAB_STOP_DEFAULT;
            if (n > left) n = left;
         end else begin
            n     = 1;
            glyph = item.character;
         end
      end
      line_column += n;
      line_closed = (line_column >= w);
      expected_runs.push_back('{glyph, color, LINE_WIDTH_W'(n), line_closed});
   endfunction

   function automatic void check_run(rsp_data_type got);
      rsp_data_type want;
      if (expected_runs.size() == 0) begin
         $display("%0t: unexpected run char=%h color=%h len=%0d end=%b", $time,
                  got.cell_char, got.cell_color, got.run_length, got.line_end);
         fail_count++;
         return;
      end
      want = expected_runs.pop_front();
      runs_checked++;
      if (got.line_end) line_ends++;
      if (got.cell_char !== want.cell_char || got.cell_color !== want.cell_color ||
          got.run_length !== want.run_length || got.line_end !== want.line_end) begin
         $write("%0t: run mismatch: expected char=%h color=%h len=%0d end=%b, ",
                $time, want.cell_char, want.cell_color, want.run_length, want.line_end);
         $display("got char=%h color=%h len=%0d end=%b",
                  got.cell_char, got.cell_color, got.run_length, got.line_end);
         fail_count++;
      end
   endfunction

   function automatic req_data_type text_item(logic kind, logic [7:0] ch,
                                              logic [POSITION_W-1:0] pos, logic ls);
      return '{kind, ch, pos, ls};
   endfunction

   // mostly well-formed lines with random content, the rest noise
   function automatic void queue_lines(int count);
      int         pushed;
      int         len;
      int         r;
      int         w;
      logic [7:0] ch;
      pushed = 0;
      w      = effective_width();
      while (pushed < count) begin
         if ($urandom_range(0, 99) < 82) begin
            len = $urandom_range(1, w + 2);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 99);
               if (r < 10) ch = CHAR_TAB;
               else if (r < 18) ch = 8'($urandom);
               else ch = 8'($urandom_range(32, 126));
               text_items.push_back(text_item(KIND_TEXT, ch, POSITION_W'(text_pos), i == 0));
               text_pos++;
               pushed++;
            end
            r = $urandom_range(0, 2);
            if (r == 0) begin
               ch = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
               text_items.push_back(text_item(KIND_TEXT, ch, POSITION_W'(text_pos), 1'b0));
               text_pos++;
               pushed++;
            end else if (r == 1) begin
               text_items.push_back(text_item(KIND_EOT, 8'($urandom), POSITION_W'($urandom), 1'b0));
               pushed++;
            end
         end else begin
            text_items.push_back(text_item(1'($urandom), 8'($urandom), POSITION_W'($urandom),
                                           1'($urandom)));
            pushed++;
         end
      end
   endfunction

   task automatic write_reg(logic [2:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_NORMAL_COLOR: shadow_normal    = value[7:0];
         REG_SELECT_COLOR: shadow_select    = value[7:0];
         REG_SEL_START:    shadow_sel_start = value[POSITION_W-1:0];
         REG_SEL_END:      shadow_sel_end   = value[POSITION_W-1:0];
         REG_LINE_WIDTH:   shadow_width     = value[LINE_WIDTH_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic random_config();
      logic [POSITION_W-1:0] sel_lo;
      int                    w;
      write_reg(REG_NORMAL_COLOR, $urandom_range(0, 255));
      write_reg(REG_SELECT_COLOR, $urandom_range(0, 255));
      text_pos = $urandom_range(0, 24'hffe000);
      sel_lo   = POSITION_W'(text_pos + $urandom_range(0, 40));
      write_reg(REG_SEL_START, sel_lo);
      write_reg(REG_SEL_END, POSITION_W'(sel_lo + $urandom_range(0, 90) - 10));
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: w = 0;
               1: w = 256;
               2: w = 257;
               default: w = 511;
            endcase
         end
         1: w = $urandom_range(1, 8);
         default: w = $urandom_range(9, 48);
      endcase
      write_reg(REG_LINE_WIDTH, w);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (text_items.size() != 0 || req_valid || expected_runs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_run(req_data);
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (text_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= text_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver flow control
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_run(rsp_data);
         if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            stall_left   <= LONG_STALL;
            rsp_ready    <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("** text_line_cell_formatter: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset config: width 80, empty selection; tabs, field extremes, dropped items
      text_items.push_back(text_item(KIND_TEXT, 8'h41, 24'h000000, 1'b1));
      text_items.push_back(text_item(KIND_TEXT, CHAR_TAB, 24'h000001, 1'b0));
      text_items.push_back(text_item(KIND_TEXT, 8'hff, 24'hffffff, 1'b0));
      text_items.push_back(text_item(KIND_TEXT, 8'h00, 24'h800000, 1'b0));
      text_items.push_back(text_item(KIND_TEXT, CHAR_TAB, 24'h000005, 1'b0));
      text_items.push_back(text_item(KIND_TEXT, CHAR_CR, 24'h000006, 1'b0));
      text_items.push_back(text_item(KIND_TEXT, 8'h7a, 24'h000007, 1'b0));
      text_items.push_back(text_item(KIND_EOT, 8'h55, 24'h000008, 1'b0));
      text_items.push_back(text_item(KIND_TEXT, CHAR_LF, 24'h000009, 1'b1));
      text_items.push_back(text_item(KIND_EOT, 8'hff, 24'hffffff, 1'b1));
      wait_drained();

      // one-cell lines, selection edges, tab clipped at the width
      write_reg(REG_NORMAL_COLOR, 0);
      write_reg(REG_SELECT_COLOR, 255);
      write_reg(REG_SEL_START, 4);
      write_reg(REG_SEL_END, 8);
      write_reg(REG_LINE_WIDTH, 1);
      @(negedge clock);
      text_items.push_back(text_item(KIND_TEXT, 8'h61, 24'd3, 1'b1));
      text_items.push_back(text_item(KIND_TEXT, 8'h61, 24'd4, 1'b1));
      text_items.push_back(text_item(KIND_TEXT, 8'h61, 24'd7, 1'b1));
      text_items.push_back(text_item(KIND_TEXT, 8'h61, 24'd8, 1'b1));
      text_items.push_back(text_item(KIND_TEXT, CHAR_TAB, 24'd5, 1'b1));
      text_items.push_back(text_item(KIND_TEXT, 8'h62, 24'd6, 1'b0));
      wait_drained();

      // zero width acts as one
      write_reg(REG_LINE_WIDTH, 0);
      @(negedge clock);
      text_items.push_back(text_item(KIND_TEXT, 8'h63, 24'd5, 1'b1));
      text_items.push_back(text_item(KIND_EOT, 8'h00, 24'd0, 1'b1));
      wait_drained();

      // oversized width, empty selection, then width lowered to the column
      write_reg(REG_LINE_WIDTH, 511);
      write_reg(REG_SEL_START, 100);
      write_reg(REG_SEL_END, 50);
      @(negedge clock);
      text_items.push_back(text_item(KIND_TEXT, CHAR_TAB, 24'd100, 1'b1));
      text_items.push_back(text_item(KIND_TEXT, 8'h64, 24'd75, 1'b0));
      wait_drained();
      write_reg(REG_LINE_WIDTH, 9);
      @(negedge clock);
      text_items.push_back(text_item(KIND_TEXT, 8'h65, 24'd76, 1'b0));
      text_items.push_back(text_item(KIND_EOT, 8'h00, 24'd0, 1'b0));
      wait_drained();
      write_reg(REG_LINE_WIDTH, 256);
      @(negedge clock);
      text_items.push_back(text_item(KIND_EOT, 8'h00, 24'd0, 1'b1));
      wait_drained();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 86 : 0;
         recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 12 : 0;
         for (int pass = 0; pass < 2; pass++) begin
            random_config();
            queue_lines(40);
            if (mode == 0 && pass == 0) stall_requests++;
            wait_drained();
            queue_lines(40);
            wait_drained();
         end
      end

      repeat (8) @(negedge clock);
      if (expected_runs.size() != 0) begin
         $display("%0t: %0d expected runs never arrived", $time, expected_runs.size());
         fail_count++;
      end
      $display("Covered %0d transfers, %0d runs (%0d line ends), %0d register writes",
               items_sent, runs_checked, line_ends, reg_writes);
      $display("widths 0 to 511, tabs, breaks, end of text, selection edges, three flow mixes");
      if (fail_count == 0) begin
         $display("** text_line_cell_formatter: PASSED **");
      end else begin
         $display("** text_line_cell_formatter: FAILED **");
      end
      $finish;
   end

endmodule
